// File: hw/rtl/btqe_pkg.sv
package btqe_pkg;

  localparam int FONT_W      = 5;
  localparam int FONT_H      = 7;
  localparam int CLIP_MARGIN = 12;
  localparam int IDX_W       = 12;
  localparam int PIX_N       = FONT_W * FONT_H;

  localparam logic [1:0] CFG_VP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_VP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_QUAD_CAP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic              new_text;
    logic [7:0]        char_code;
    logic [IDX_W-1:0]  char_index;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] quad_x;
    logic [15:0] quad_y;
    logic [7:0]  quad_char;
    logic [15:0] glyph_total;
    logic [15:0] quad_index;
    logic        stored;
    logic        capacity_exceeded;
    logic        last;
  } out_item_t;

  // 5x7 font, row 0 in the top bits, column 0 first; unknown bytes draw '?'
  function automatic logic [PIX_N-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
    unique case (c)
      8'h30: glyph_bits = {5'h1F, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h1F};
      8'h31: glyph_bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32: glyph_bits = {5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h33: glyph_bits = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h34: glyph_bits = {5'h12, 5'h12, 5'h12, 5'h1F, 5'h02, 5'h02, 5'h02};
      8'h35: glyph_bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      8'h36: glyph_bits = {5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37: glyph_bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: glyph_bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39: glyph_bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E};
      8'h41: glyph_bits = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h42: glyph_bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      8'h43: glyph_bits = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
      8'h44: glyph_bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45: glyph_bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h46: glyph_bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h47: glyph_bits = {5'h0F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0F};
      8'h48: glyph_bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h49: glyph_bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h4A: glyph_bits = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
      8'h4B: glyph_bits = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4C: glyph_bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h4D: glyph_bits = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E: glyph_bits = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F: glyph_bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: glyph_bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h51: glyph_bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      8'h52: glyph_bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      8'h53: glyph_bits = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h54: glyph_bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: glyph_bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h56: glyph_bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      8'h57: glyph_bits = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      8'h58: glyph_bits = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      8'h59: glyph_bits = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5A: glyph_bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      8'h2E: glyph_bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      8'h2D: glyph_bits = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      8'h5F: glyph_bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      8'h3A: glyph_bits = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
      8'h2F: glyph_bits = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
      8'h20: glyph_bits = '0;
      default: glyph_bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04};
    endcase
  endfunction

endpackage

// File: hw/rtl/bitmap_text_glyph_quad_emitter_core.sv
// Glyph quad emitter: one character beat in, one 2x2 (GLYPH_PIXEL square) quad beat out per
// lit font pixel. A character that is rejected (zero viewport, negative origin, index out of
// range, bottom clip, blank glyph) finishes in its accept cycle. Otherwise the x position
// origin_x + char_index*6*GLYPH_PIXEL is formed by a bit-serial shift-add over the 12 index
// bits, a check state then tests the right clip, and the 35-bit glyph shift register is
// scanned one pixel per cycle, held while out_stall blocks a lit pixel, up to the last lit
// pixel. The next character is accepted once the scan ends, while its final quad may still
// wait in the output register.
module bitmap_text_glyph_quad_emitter_core #(
  parameter int MAX_TEXT_LEN = 4096,
  parameter int GLYPH_PIXEL  = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  btqe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output btqe_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import btqe_pkg::*;

  localparam int STEP      = (FONT_W + 1) * GLYPH_PIXEL;
  localparam int BX_W      = IDX_W + $clog2(STEP + 1) + 2;
  localparam int MUL_CNT_W = $clog2(IDX_W);
  localparam int COL_W     = $clog2(FONT_W);
  localparam int LEN_W     = 17;

  state_t                 state_r, state_nxt;
  logic [15:0]            vp_w_r, vp_h_r, cap_r;
  logic [15:0]            glyph_cnt_r, quad_cnt_r;
  logic                   ovf_r;
  logic [7:0]             code_r;
  logic [15:0]            x_r, y_r;
  logic [BX_W-1:0]        acc_r, step_r;
  logic [IDX_W-1:0]       idx_sr_r;
  logic [MUL_CNT_W-1:0]   mul_cnt_r;
  logic [PIX_N-1:0]       pix_sr_r;
  logic [COL_W-1:0]       col_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic                   in_fire, skip, idx_big, y_fail, x_fail;
  logic [15:0]            max_x, max_y;
  logic [PIX_N-1:0]       glyph_in;
  logic                   lit, out_free, advance, emit, fits, rest_zero;

  assign in_fire   = in_valid && !in_stall;
  assign max_x     = (vp_w_r > 16'(CLIP_MARGIN)) ? vp_w_r - 16'(CLIP_MARGIN) : vp_w_r;
  assign max_y     = (vp_h_r > 16'(CLIP_MARGIN)) ? vp_h_r - 16'(CLIP_MARGIN) : vp_h_r;
  assign idx_big   = LEN_W'(in_data.char_index) >= LEN_W'(MAX_TEXT_LEN);
  assign y_fail    = ({1'b0, in_data.origin_y} + LEN_W'(FONT_H * GLYPH_PIXEL)) > {1'b0, max_y};
  assign glyph_in  = glyph_bits(in_data.char_code);
  assign skip      = (vp_w_r == '0) || (vp_h_r == '0) || in_data.origin_x[15] ||
                     in_data.origin_y[15] || idx_big || y_fail || (glyph_in == '0);
  assign x_fail    = (acc_r + BX_W'(FONT_W * GLYPH_PIXEL)) > BX_W'(max_x);
  assign lit       = pix_sr_r[PIX_N-1];
  assign rest_zero = (pix_sr_r[PIX_N-2:0] == '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = (state_r == ST_SCAN) && (!lit || out_free);
  assign emit      = (state_r == ST_SCAN) && lit && out_free;
  assign fits      = quad_cnt_r < cap_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && !skip) state_nxt = ST_MUL;
      ST_MUL:   if (mul_cnt_r == '0) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = x_fail ? ST_IDLE : ST_SCAN;
      ST_SCAN:  if (advance && rest_zero) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vp_w_r      <= 16'd640;
      vp_h_r      <= 16'd480;
      cap_r       <= 16'hFFFF;
      glyph_cnt_r <= '0;
      quad_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VP_WIDTH:  vp_w_r <= cfg_wdata;
          CFG_VP_HEIGHT: vp_h_r <= cfg_wdata;
          CFG_QUAD_CAP:  cap_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire && in_data.new_text) begin
        glyph_cnt_r <= '0;
        quad_cnt_r  <= '0;
        ovf_r       <= 1'b0;
      end else begin
        if (state_r == ST_CHECK && !x_fail && glyph_cnt_r != 16'hFFFF)
          glyph_cnt_r <= glyph_cnt_r + 16'd1;
        if (emit && fits) quad_cnt_r <= quad_cnt_r + 16'd1;
        if (emit && !fits) ovf_r <= 1'b1;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r     <= BX_W'($unsigned(in_data.origin_x));
      step_r    <= BX_W'(STEP);
      idx_sr_r  <= in_data.char_index;
      mul_cnt_r <= MUL_CNT_W'(IDX_W - 1);
      pix_sr_r  <= glyph_in;
      code_r    <= in_data.char_code;
      y_r       <= $unsigned(in_data.origin_y);
      col_r     <= '0;
    end
    if (state_r == ST_MUL) begin
      if (idx_sr_r[0]) acc_r <= acc_r + step_r;
      step_r    <= step_r << 1;
      idx_sr_r  <= idx_sr_r >> 1;
      mul_cnt_r <= mul_cnt_r - MUL_CNT_W'(1);
    end
    if (state_r == ST_CHECK) x_r <= acc_r[15:0];
    if (advance) begin
      pix_sr_r <= pix_sr_r << 1;
      if (col_r == COL_W'(FONT_W - 1)) begin
        col_r <= '0;
        x_r   <= acc_r[15:0];
        y_r   <= y_r + 16'(GLYPH_PIXEL);
      end else begin
        col_r <= col_r + COL_W'(1);
        x_r   <= x_r + 16'(GLYPH_PIXEL);
      end
    end
    if (emit) begin
      out_r.quad_x            <= x_r;
      out_r.quad_y            <= y_r;
      out_r.quad_char         <= code_r;
      out_r.glyph_total       <= glyph_cnt_r;
      out_r.quad_index        <= quad_cnt_r;
      out_r.stored            <= fits;
      out_r.capacity_exceeded <= ovf_r || !fits;
      out_r.last              <= rest_zero;
    end
  end

  a_scan_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pix_sr_r != '0))
    else $error("scan running on an empty glyph");

  a_stored_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && fits) |=> (quad_cnt_r == $past(quad_cnt_r) + 16'd1))
    else $error("stored quad did not advance the quad count");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.stored) |-> out_r.capacity_exceeded)
    else $error("dropped quad without overflow flag");

  a_glyph_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(in_fire && in_data.new_text)) |->
      (glyph_cnt_r >= $past(glyph_cnt_r)))
    else $error("glyph count went down without new text");

endmodule
